FILE: design/slcan_pkg.sv
// shared constants and codes for the ascii can line parser
`default_nettype none

package slcan_pkg;

  localparam int MAX_DATA_BYTES_DEF = 8;

  localparam logic [4:0] POS_MAX = 5'd31;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_T_UP = 8'h54;
  localparam logic [7:0] CH_R_UP = 8'h52;
  localparam logic [7:0] CH_T_LO = 8'h74;
  localparam logic [7:0] CH_R_LO = 8'h72;

  localparam logic [4:0] STD_ID_LEN = 5'd3;
  localparam logic [4:0] EXT_ID_LEN = 5'd8;
  localparam logic [3:0] DLC_MAX    = 4'd8;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_STD  = 2'd1,
    KIND_EXT  = 2'd2,
    KIND_UNK  = 2'd3
  } line_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_PFX   = 2'd1,
    ST_TOO_SHORT = 2'd2,
    ST_BAD_HEX   = 2'd3
  } status_t;

endpackage

`default_nettype wire

FILE: design/slcan_ascii_frame_parser_top.sv
// ascii serial can line parser: one byte per word in, one parsed frame per line out
`default_nettype none

// Takes one received character per input word and returns one frame word when a
// non-empty line ends at CR or LF. Every character is parsed in the cycle it is
// accepted by a single combinational pass over the line state, so one word can be
// accepted every clock cycle. The frame for a line appears in the result register
// in the cycle after its terminator is accepted and stays there until taken; in_ready
// is low only while that register holds a frame that the sink has not yet taken.
module slcan_ascii_frame_parser_top #(
  parameter int MAX_DATA_BYTES = slcan_pkg::MAX_DATA_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_frame_id,
  output logic             out_is_extended,
  output logic [3:0]       out_data_len,
  output logic [7:0]       out_byte_zero,
  output logic [7:0]       out_byte_one,
  output logic [7:0]       out_byte_two,
  output logic [7:0]       out_byte_three,
  output logic [7:0]       out_byte_four,
  output logic [7:0]       out_byte_five,
  output logic [7:0]       out_byte_six,
  output logic [7:0]       out_byte_seven
);

  import slcan_pkg::*;

  typedef logic [MAX_DATA_BYTES-1:0][7:0] data_arr_t;

  typedef struct packed {
    logic [31:0] id;
    logic [3:0]  len;
    logic [3:0]  hi;
    data_arr_t   data;
    logic        stopped;
    logic        herr;
  } parse_t;

  typedef logic [7:0][7:0] frame_bytes_t;

  // line state
  logic [4:0]   pos_r, pos_nxt;
  logic [4:0]   held_r, held_nxt;
  line_kind_t   kind_r, kind_nxt;
  parse_t       ps_r, ps_nxt;

  // result register
  logic         out_valid_r;
  status_t      status_r, status_nxt;
  logic [31:0]  id_r, id_nxt;
  logic         ext_r, ext_nxt;
  logic [3:0]   len_r, len_nxt;
  frame_bytes_t bytes_r, bytes_nxt;
  logic         emit;

  logic         in_acc;
  logic         is_term;
  logic         is_ws;
  logic         hex_ok;
  logic [3:0]   hex_v;

  function automatic logic [4:0] sat_add(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, POS_MAX}) ? POS_MAX : s[4:0];
  endfunction

  function automatic parse_t take_char(input parse_t s, input line_kind_t kind,
                                       input logic [4:0] p, input logic ok,
                                       input logic [3:0] v);
    parse_t     r;
    logic [4:0] idl;
    logic [4:0] d;
    logic [3:0] i;
    r   = s;
    idl = (kind == KIND_EXT) ? EXT_ID_LEN : STD_ID_LEN;
    d   = p - idl - 5'd2;
    i   = d[4:1];
    if (kind == KIND_STD || kind == KIND_EXT) begin
      if (p >= 5'd1 && p <= idl) begin
        if (!ok) r.herr = 1'b1;
        else     r.id = {s.id[27:0], v};
      end else if (p == idl + 5'd1) begin
        if (!ok) r.herr = 1'b1;
        else     r.len = (v > DLC_MAX) ? DLC_MAX : v;
      end else if (p > idl + 5'd1) begin
        if (!s.stopped) begin
          if (!ok) begin
            r.stopped = 1'b1;
          end else if (!d[0]) begin
            r.hi = v;
          end else begin
            for (int k = 0; k < MAX_DATA_BYTES; k++) begin
              if (i == 4'(k) && i < s.len) r.data[k] = {s.hi, v};
            end
          end
        end
      end
    end
    return r;
  endfunction

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  assign is_term = (in_byte == CH_CR) || (in_byte == CH_LF);
  assign is_ws   = (in_byte == CH_SP) || (in_byte == CH_TAB) ||
                   (in_byte == CH_VT) || (in_byte == CH_FF);

  always_comb begin
    hex_ok = 1'b0;
    hex_v  = in_byte[3:0];
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_ok = 1'b1;
    end else if ((in_byte >= 8'h41 && in_byte <= 8'h46) ||
                 (in_byte >= 8'h61 && in_byte <= 8'h66)) begin
      hex_ok = 1'b1;
      hex_v  = in_byte[3:0] + 4'd9;
    end
  end

  always_comb begin
    parse_t     s;
    logic [4:0] p;
    logic [4:0] idl;
    pos_nxt    = pos_r;
    held_nxt   = held_r;
    kind_nxt   = kind_r;
    ps_nxt     = ps_r;
    emit       = 1'b0;
    status_nxt = ST_OK;
    id_nxt     = '0;
    ext_nxt    = 1'b0;
    len_nxt    = '0;
    bytes_nxt  = '0;
    s          = ps_r;
    p          = pos_r;
    idl        = (kind_r == KIND_EXT) ? EXT_ID_LEN : STD_ID_LEN;
    if (in_acc) begin
      if (is_term) begin
        if (kind_r != KIND_NONE) begin
          emit = 1'b1;
          if (kind_r == KIND_UNK)            status_nxt = ST_BAD_PFX;
          else if (pos_r < idl + 5'd2)       status_nxt = ST_TOO_SHORT;
          else if (ps_r.herr)                status_nxt = ST_BAD_HEX;
          else                               status_nxt = ST_OK;
          if (!(kind_r == KIND_UNK) && !(pos_r < idl + 5'd2) && !ps_r.herr) begin
            id_nxt  = ps_r.id;
            ext_nxt = (kind_r == KIND_EXT);
            len_nxt = ps_r.len;
            for (int k = 0; k < MAX_DATA_BYTES; k++) begin
              bytes_nxt[k] = ps_r.data[k];
            end
          end
        end
        pos_nxt  = '0;
        held_nxt = '0;
        kind_nxt = KIND_NONE;
        ps_nxt   = '0;
      end else if (is_ws) begin
        if (kind_r != KIND_NONE) held_nxt = sat_add(held_r, 5'd1);
      end else if (kind_r == KIND_NONE) begin
        if (in_byte == CH_T_UP || in_byte == CH_R_UP)      kind_nxt = KIND_EXT;
        else if (in_byte == CH_T_LO || in_byte == CH_R_LO) kind_nxt = KIND_STD;
        else                                               kind_nxt = KIND_UNK;
        pos_nxt = 5'd1;
      end else begin
        // held whitespace turned out to be inside the line
        if (held_r != '0) begin
          s = take_char(s, kind_r, pos_r, 1'b0, 4'd0);
          p = sat_add(pos_r, held_r);
        end
        held_nxt = '0;
        ps_nxt   = take_char(s, kind_r, p, hex_ok, hex_v);
        pos_nxt  = sat_add(p, 5'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      held_r      <= '0;
      kind_r      <= KIND_NONE;
      ps_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      held_r <= held_nxt;
      kind_r <= kind_nxt;
      ps_r   <= ps_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status_r <= status_nxt;
      id_r     <= id_nxt;
      ext_r    <= ext_nxt;
      len_r    <= len_nxt;
      bytes_r  <= bytes_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_frame_id    = id_r;
  assign out_is_extended = ext_r;
  assign out_data_len    = len_r;
  assign out_byte_zero   = bytes_r[0];
  assign out_byte_one    = bytes_r[1];
  assign out_byte_two    = bytes_r[2];
  assign out_byte_three  = bytes_r[3];
  assign out_byte_four   = bytes_r[4];
  assign out_byte_five   = bytes_r[5];
  assign out_byte_six    = bytes_r[6];
  assign out_byte_seven  = bytes_r[7];

endmodule

`default_nettype wire
